>>> rtl/core/rrct_pkg.sv
// Shared constants and types for the round-robin completion times unit.
package rrct_pkg;

   localparam int MaxProcs = 16;
   localparam int IdxW = $clog2(MaxProcs);
   localparam int CntW = $clog2(MaxProcs + 1);
   localparam int TimeW = 21;

   localparam logic [0:0] CSR_TIME_SLICE = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // store the incoming job
      logic scan_start; // begin an admission scan
      logic scan_step;  // examine one job
      logic jump;       // advance time to the earliest pending arrival
      logic pop;        // take the queue head
      logic run;        // run the popped job for up to one slice
      logic finish;     // retire the running job or requeue it
      logic clear;      // reset the set state
   } rrct_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // scan has covered every job
      logic scan_found; // scan admitted a job on this pass
      logic queue_empty;
      logic any_pending;
      logic all_done;
   } rrct_sts_type;

endpackage

>>> rtl/core/rrct_ctrl.sv
// Controller state machine: sequences loads, admission scans and slices.
module rrct_ctrl import rrct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         last_job,
   input  rrct_sts_type sts,
   output rrct_cmd_type cmd,
   output logic         busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_POP   = 3'd3;
   localparam logic [2:0] S_RUN   = 3'd4;
   localparam logic [2:0] S_SCAN2 = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_job) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // pick the next action: done, jump and admit, or dispatch
            priority if (sts.all_done) begin
               cmd.clear = 1'b1;
               state_in = S_IDLE;
            end else if (sts.queue_empty) begin
               if (sts.any_pending) begin
                  cmd.jump = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_POP;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.scan_found) cmd.scan_start = 1'b1;
               else state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.run = 1'b1;
            cmd.scan_start = 1'b1;
            state_in = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.scan_found) cmd.scan_start = 1'b1;
               else state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> rtl/core/rrct_dp.sv
// Datapath: job stores, ready queue, time counter and result formation.
module rrct_dp import rrct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rrct_cmd_type cmd,
   input  logic [15:0]  arrival_time,
   input  logic [15:0]  burst_time,
   input  logic [15:0]  slice,
   output rrct_sts_type sts,
   output logic         done_strobe,
   output logic [3:0]   job_index,
   output logic [20:0]  completion_time,
   output logic [20:0]  turnaround_time,
   output logic [19:0]  queue_wait,
   output logic         last_result
);

   logic [15:0] arr_mem [MaxProcs];
   logic [15:0] bur_mem [MaxProcs];
   logic [15:0] rem_mem [MaxProcs];
   logic [IdxW-1:0] fifo_mem [MaxProcs];

   logic [MaxProcs-1:0] queued_ff, queued_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] loaded_ff, loaded_in;
   logic [CntW-1:0] fin_ff, fin_in;
   logic [TimeW-1:0] time_ff, time_in;

   // scan state: walks all jobs, keeps best admissible one
   logic [IdxW-1:0] scan_ff, scan_in;
   logic            best_vld_ff, best_vld_in;
   logic [IdxW-1:0] best_ff, best_in;

   // job being run and its remaining burst, set by a pop
   logic [IdxW-1:0] cur_ff, cur_in;
   logic [15:0]     remv_ff, remv_in;

   logic [IdxW-1:0] tail;
   logic [15:0]     min_arr;
   logic            any_pend;
   logic [15:0]     run_len;
   logic [15:0]     rem_after;
   logic            scan_last;
   logic            elig;
   logic            pick_vld;
   logic [IdxW-1:0] pick_idx;

   logic [15:0]         tree_arr [MaxProcs];
   logic [MaxProcs-1:0] tree_vld;

   assign tail = IdxW'((CntW+1)'(head_ff) + (CntW+1)'(count_ff));
   assign scan_last = ((CntW)'(scan_ff) + 1'b1) >= loaded_ff;
   assign elig = !queued_ff[scan_ff] && ((CntW)'(scan_ff) < loaded_ff) &&
                 (TimeW'(arr_mem[scan_ff]) <= time_ff) &&
                 (!best_vld_ff || arr_mem[scan_ff] < arr_mem[best_ff]);
   assign pick_vld = best_vld_ff || elig;
   assign pick_idx = elig ? scan_ff : best_ff;

   // minimum pending arrival over the loaded jobs; pairwise tree, log2 levels
   always_comb begin
      for (int i = 0; i < MaxProcs; i++) begin
         tree_arr[i] = arr_mem[i];
         tree_vld[i] = ((CntW)'(i) < loaded_ff) && !queued_ff[i];
      end
      for (int w = MaxProcs / 2; w >= 1; w = w >> 1) begin
         for (int i = 0; i < w; i++) begin
            if (tree_vld[2*i+1] && (!tree_vld[2*i] || tree_arr[2*i+1] < tree_arr[2*i]))
               tree_arr[i] = tree_arr[2*i+1];
            else
               tree_arr[i] = tree_arr[2*i];
            tree_vld[i] = tree_vld[2*i] || tree_vld[2*i+1];
         end
      end
      min_arr = tree_arr[0];
      any_pend = tree_vld[0];
   end

   assign run_len = (remv_ff < slice) ? remv_ff : slice;
   assign rem_after = remv_ff - run_len;

   always_comb begin
      queued_in = queued_ff;
      head_in = head_ff;
      count_in = count_ff;
      loaded_in = loaded_ff;
      fin_in = fin_ff;
      time_in = time_ff;
      scan_in = scan_ff;
      best_vld_in = best_vld_ff;
      best_in = best_ff;
      cur_in = cur_ff;
      remv_in = remv_ff;
      if (cmd.load && loaded_ff < CntW'(MaxProcs)) begin
         queued_in[loaded_ff[IdxW-1:0]] = 1'b0;
         loaded_in = loaded_ff + 1'b1;
      end
      if (cmd.jump && TimeW'(min_arr) > time_ff) time_in = TimeW'(min_arr);
      if (cmd.scan_step) begin
         best_in = pick_idx;
         best_vld_in = pick_vld;
         scan_in = scan_ff + 1'b1;
         if (scan_last && pick_vld) begin
            // admit the best job of this pass, then rescan
            queued_in[pick_idx] = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.scan_start) begin
         scan_in = '0;
         best_vld_in = 1'b0;
      end
      if (cmd.pop) begin
         cur_in = fifo_mem[head_ff];
         remv_in = rem_mem[fifo_mem[head_ff]];
         head_in = head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.run) begin
         time_in = time_ff + TimeW'(run_len);
         remv_in = rem_after;
      end
      if (cmd.finish) begin
         if (remv_ff != 16'd0) count_in = count_ff + 1'b1;
         else fin_in = fin_ff + 1'b1;
      end
      if (cmd.clear) begin
         queued_in = '0;
         head_in = '0;
         count_in = '0;
         loaded_in = '0;
         fin_in = '0;
         time_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= '0;
         head_ff <= '0;
         count_ff <= '0;
         loaded_ff <= '0;
         fin_ff <= '0;
         time_ff <= '0;
         best_vld_ff <= 1'b0;
      end else begin
         queued_ff <= queued_in;
         head_ff <= head_in;
         count_ff <= count_in;
         loaded_ff <= loaded_in;
         fin_ff <= fin_in;
         time_ff <= time_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      best_ff <= best_in;
      cur_ff <= cur_in;
      remv_ff <= remv_in;
   end

   // store writes
   always_ff @(posedge clock) begin
      if (cmd.load && loaded_ff < CntW'(MaxProcs)) begin
         arr_mem[loaded_ff[IdxW-1:0]] <= arrival_time;
         bur_mem[loaded_ff[IdxW-1:0]] <= (burst_time == 16'd0) ? 16'd1 : burst_time;
         rem_mem[loaded_ff[IdxW-1:0]] <= (burst_time == 16'd0) ? 16'd1 : burst_time;
      end
      if (cmd.run) rem_mem[cur_ff] <= rem_after;
      if (cmd.scan_step && scan_last && pick_vld)
         fifo_mem[tail] <= pick_idx;
      else if (cmd.finish && remv_ff != 16'd0)
         fifo_mem[tail] <= cur_ff;
   end

   logic [TimeW-1:0] tat;
   assign tat = time_ff - TimeW'(arr_mem[cur_ff]);

   // result register
   always_ff @(posedge clock) begin
      if (reset) done_strobe <= 1'b0;
      else done_strobe <= cmd.finish && (remv_ff == 16'd0);
      job_index <= 4'(cur_ff);
      completion_time <= time_ff;
      turnaround_time <= tat;
      queue_wait <= 20'(tat - TimeW'(bur_mem[cur_ff]));
      last_result <= (fin_ff + 1'b1) == loaded_ff;
   end

   assign sts.scan_done = scan_last;
   assign sts.scan_found = pick_vld;
   assign sts.queue_empty = (count_ff == '0);
   assign sts.any_pending = any_pend;
   assign sts.all_done = (fin_ff == loaded_ff);

endmodule

>>> rtl/core/round_robin_completion_times_unit.sv
// Jobs load one per cycle while idle; the item with last_job runs round-robin
// over the stored jobs, busy staying high throughout. Each dispatch steps through
// a check, a pop, a run, an admission scan that walks the job stores in sequence
// and restarts after each admitted job, and a retire. Results appear on
// rsp_valid for one cycle each and cannot be stalled by the receiver.
module round_robin_completion_times_unit import rrct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_time,
   input  logic        req_last_job,
   output logic        rsp_valid,
   output logic [3:0]  rsp_job_index,
   output logic [20:0] rsp_completion_time,
   output logic [20:0] rsp_turnaround_time,
   output logic [19:0] rsp_queue_wait,
   output logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   rrct_cmd_type cmd;
   rrct_sts_type sts;
   logic [15:0]  slice_ff;
   logic [15:0]  slice_eff;
   logic         go;

   assign pready = 1'b1;
   assign go = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) slice_ff <= 16'd4;
      else if (psel && penable && pwrite && paddr[2] == CSR_TIME_SLICE && paddr[1:0] == 2'b00)
         slice_ff <= pwdata[15:0];
   end

   assign prdata = (paddr[2] == CSR_TIME_SLICE) ? {16'd0, slice_ff} : 32'd0;
   assign slice_eff = (slice_ff == 16'd0) ? 16'd1 : slice_ff;

   rrct_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(go), .last_job(req_last_job),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   rrct_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .arrival_time(req_arrival_time), .burst_time(req_burst_time),
      .slice(slice_eff), .sts(sts), .done_strobe(rsp_valid),
      .job_index(rsp_job_index), .completion_time(rsp_completion_time),
      .turnaround_time(rsp_turnaround_time), .queue_wait(rsp_queue_wait),
      .last_result(rsp_last_result)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !sts.queue_empty) else $error("pop from empty queue");
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result while idle");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.pop, cmd.run, cmd.finish, cmd.clear}))
      else $error("conflicting commands");

endmodule

>>> bench/testbench.sv
// Testbench for the round-robin completion times unit: directed table, then random job sets.
`timescale 1ns / 1ps

module testbench import rrct_pkg::*; ();

   localparam int CycleLimit = 3000000;
   localparam int RandomJobs = 285;

   typedef struct packed {
      logic [3:0]  job_index;
      logic [20:0] completion_time;
      logic [20:0] turnaround_time;
      logic [19:0] queue_wait;
      logic        last_result;
   } finish_word_type;

   typedef struct {
      logic [15:0]     arrival;
      logic [15:0]     burst;
      logic            last;
      bit              typed;
      finish_word_type word;
   } job_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_arrival_time;
   logic [15:0] req_burst_time;
   logic        req_last_job;
   logic        rsp_valid;
   logic [3:0]  rsp_job_index;
   logic [20:0] rsp_completion_time;
   logic [20:0] rsp_turnaround_time;
   logic [19:0] rsp_queue_wait;
   logic        rsp_last_result;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   round_robin_completion_times_unit DUT (.*);

   // scheduler copy
   logic [15:0] slice_reg;
   logic [15:0] arr_mem [MaxProcs];
   logic [15:0] bur_mem [MaxProcs];
   logic [15:0] rem_mem [MaxProcs];
   bit          queued   [MaxProcs];
   logic [3:0]  ready_ring [MaxProcs];
   logic [3:0]  ring_head;
   int          ring_count;
   int          jobs_loaded;
   logic [20:0] now_t;

   finish_word_type finish_queue[$];
   int errors = 0;
   int cycles = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void ring_push(input logic [3:0] j);
      if (ring_count < MaxProcs) begin
         ready_ring[4'(ring_head + ring_count)] = j;
         ring_count++;
      end
   endfunction

   function automatic void admit_arrived();
      int best;
      forever begin
         best = -1;
         for (int i = 0; i < jobs_loaded; i++)
            if (!queued[i] && arr_mem[i] <= now_t &&
                (best < 0 || arr_mem[i] < arr_mem[best]))
               best = i;
         if (best < 0) return;
         queued[best] = 1'b1;
         ring_push(4'(best));
      end
   endfunction

   // Store one job; on the last job schedule the set and, if push_words is set, queue its finish words.
   function automatic void schedule_job(input logic [15:0] arr, input logic [15:0] bur,
                                        input logic last, input bit push_words);
      logic [15:0]     eff_slice, run;
      logic [3:0]      j;
      logic [20:0]     tat, nxt;
      bit              found;
      int              done;
      finish_word_type w;
      eff_slice = (slice_reg == 0) ? 16'd1 : slice_reg;
      if (jobs_loaded < MaxProcs) begin
         arr_mem[jobs_loaded] = arr;
         bur_mem[jobs_loaded] = (bur == 0) ? 16'd1 : bur;
         rem_mem[jobs_loaded] = (bur == 0) ? 16'd1 : bur;
         queued[jobs_loaded] = 1'b0;
         jobs_loaded++;
      end
      if (!last) return;
      now_t = 0;
      done = 0;
      while (done < jobs_loaded) begin
         if (ring_count == 0) begin
            found = 1'b0;
            nxt = 0;
            for (int i = 0; i < jobs_loaded; i++)
               if (!queued[i] && (!found || arr_mem[i] < nxt)) begin
                  nxt = arr_mem[i];
                  found = 1'b1;
               end
            if (!found) break;
            if (nxt > now_t) now_t = nxt;
            admit_arrived();
         end
         j = ready_ring[ring_head];
         ring_head = ring_head + 1;
         ring_count--;
         run = (rem_mem[j] < eff_slice) ? rem_mem[j] : eff_slice;
         now_t = now_t + run;
         rem_mem[j] = rem_mem[j] - run;
         admit_arrived();
         if (rem_mem[j] != 0) begin
            ring_push(j);
         end else begin
            done++;
            tat = now_t - arr_mem[j];
            w.job_index = j;
            w.completion_time = now_t;
            w.turnaround_time = tat;
            w.queue_wait = 20'(tat - bur_mem[j]);
            w.last_result = (done == jobs_loaded);
            if (push_words) finish_queue.push_back(w);
         end
      end
      for (int i = 0; i < MaxProcs; i++) queued[i] = 1'b0;
      ring_head = 0;
      ring_count = 0;
      jobs_loaded = 0;
      now_t = 0;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      finish_word_type w;
      if (!reset && rsp_valid) begin
         if (finish_queue.size() == 0) begin
            report_mismatch("unexpected word, index", rsp_job_index, 0);
         end else begin
            w = finish_queue.pop_front();
            if (rsp_job_index !== w.job_index)
               report_mismatch("job_index", rsp_job_index, w.job_index);
            if (rsp_completion_time !== w.completion_time)
               report_mismatch("completion_time", rsp_completion_time, w.completion_time);
            if (rsp_turnaround_time !== w.turnaround_time)
               report_mismatch("turnaround_time", rsp_turnaround_time, w.turnaround_time);
            if (rsp_queue_wait !== w.queue_wait)
               report_mismatch("queue_wait", rsp_queue_wait, w.queue_wait);
            if (rsp_last_result !== w.last_result)
               report_mismatch("last_result", rsp_last_result, w.last_result);
         end
      end
   end

   // Hold start high across back-to-back words; lower it only for a gap before this word.
   task automatic send_job(input logic [15:0] arr, input logic [15:0] bur, input logic last,
                           input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_arrival_time <= arr;
      req_burst_time <= bur;
      req_last_job <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (finish_queue.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // idle between accesses
      @(posedge clock);
   endtask

   task automatic set_slice(input logic [15:0] value);
      logic [31:0] rd;
      drain();
      csr_access(1'b1, {CSR_TIME_SLICE, 2'b00}, {16'hFFFF, value}, rd);
      slice_reg = value;
      csr_access(1'b0, {CSR_TIME_SLICE, 2'b00}, 32'd0, rd);
      if (rd[15:0] !== value) report_mismatch("time_slice readback", rd[15:0], value);
   endtask

   function automatic job_row_type row(input logic [15:0] arr, input logic [15:0] bur,
                                       input logic last);
      row.arrival = arr;
      row.burst = bur;
      row.last = last;
      row.typed = 1'b0;
      row.word = '0;
   endfunction

   function automatic job_row_type typed_row(input logic [15:0] arr, input logic [15:0] bur,
                                             input logic [20:0] ct, input logic [20:0] tat,
                                             input logic [19:0] wt);
      typed_row = row(arr, bur, 1'b1);
      typed_row.typed = 1'b1;
      typed_row.word = {4'd0, ct, tat, wt, 1'b1};
   endfunction

   initial begin
      job_row_type table_rows[$];
      logic [31:0] rd;
      logic [15:0] eff, arr, bur;
      int set_size, jobs_sent, phase, quiet;
      logic [15:0] slice_plan[7];

      reset = 1'b1;
      start = 1'b0;
      req_arrival_time = '0;
      req_burst_time = '0;
      req_last_job = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      slice_reg = 16'd4;
      ring_head = 0;
      ring_count = 0;
      jobs_loaded = 0;
      now_t = 0;
      for (int i = 0; i < MaxProcs; i++) queued[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset slice of 4
      table_rows.push_back(typed_row(16'd0, 16'd5, 21'd5, 21'd5, 20'd0));
      // zero burst runs as one
      table_rows.push_back(typed_row(16'd0, 16'd0, 21'd1, 21'd1, 20'd0));
      table_rows.push_back(typed_row(16'hFFFF, 16'hFFFF, 21'd131070, 21'd65535, 20'd0));
      table_rows.push_back(row(16'd0, 16'd10, 1'b0));
      table_rows.push_back(row(16'd2, 16'd3, 1'b0));
      table_rows.push_back(row(16'd1, 16'd6, 1'b1));
      // full store, then a dropped job carrying last_job
      for (int i = 0; i < MaxProcs; i++)
         table_rows.push_back(row(16'((i * 7) % 23), 16'(1 + (i % 9)), 1'b0));
      table_rows.push_back(row(16'd3, 16'd4, 1'b1));

      foreach (table_rows[k]) begin
         if (table_rows[k].typed) begin
            schedule_job(table_rows[k].arrival, table_rows[k].burst, 1'b1, 1'b0);
            finish_queue.push_back(table_rows[k].word);
         end else begin
            schedule_job(table_rows[k].arrival, table_rows[k].burst, table_rows[k].last, 1'b1);
         end
         send_job(table_rows[k].arrival, table_rows[k].burst, table_rows[k].last,
                  $urandom_range(0, 3));
      end

      // out-of-range register index: ignore
      drain();
      csr_access(1'b1, 3'd4, 32'd9, rd);

      slice_plan[0] = 16'd1;
      slice_plan[1] = 16'd0;
      slice_plan[2] = 16'd7;
      slice_plan[3] = 16'hFFFF;
      slice_plan[4] = 16'($urandom_range(2, 64));
      slice_plan[5] = 16'($urandom_range(4096, 65535));
      slice_plan[6] = 16'($urandom_range(1, 65535));

      jobs_sent = 0;
      phase = 0;
      while (jobs_sent < RandomJobs) begin
         if (jobs_sent >= phase * 45 && phase < 7) begin
            set_slice(slice_plan[phase]);
            phase++;
         end
         eff = (slice_reg == 0) ? 16'd1 : slice_reg;
         set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
         quiet = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < set_size; i++) begin
            arr = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            if (eff >= 16'd4096 && $urandom_range(0, 1))
               bur = 16'($urandom);
            else
               bur = 16'($urandom_range(0, (eff * 6 > 65535) ? 65535 : eff * 6));
            schedule_job(arr, bur, i == set_size - 1, 1'b1);
            send_job(arr, bur, i == set_size - 1, quiet ? 0 : $urandom_range(0, 14));
            jobs_sent++;
         end
         if ($urandom_range(0, 9) == 0) drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/rrct_pkg.sv
rtl/core/rrct_ctrl.sv
rtl/core/rrct_dp.sv
rtl/core/round_robin_completion_times_unit.sv
bench/testbench.sv
